FILE: hw/rtl/touch_sample_trimmed_mean_assert.svh
// Assertion macros used by the checker file.
`ifndef TOUCH_SAMPLE_TRIMMED_MEAN_ASSERT_SVH
`define TOUCH_SAMPLE_TRIMMED_MEAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TSTM_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is low.
`define TSTM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: label");

`endif

FILE: hw/rtl/tstm_pkg.sv
// ---------------------------------------------------------------------------
// tstm_pkg
// Shared types, constants and control structs of the trimmed-mean filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tstm_pkg;

    localparam int SAMPLE_COUNT = 10;
    localparam int TRIM_LOW     = 3;
    localparam int SAMPLE_BITS  = 12;
    localparam int KEEP_COUNT   = 5;

    localparam int CNT_W  = $clog2(SAMPLE_COUNT);
    localparam int RANK_W = $clog2(KEEP_COUNT);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(KEEP_COUNT);

    // floor(s / KEEP_COUNT) = (s * RECIP) >> DIV_SHIFT, exact for s < 2**(SUM_W+1)
    localparam int DIV_SHIFT = SUM_W + 3;
    localparam int RECIP     = (1 << DIV_SHIFT) / KEEP_COUNT + 1;
    localparam int RECIP_W   = DIV_SHIFT - 2;
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam int CFG_IDX_W = 2;

    localparam logic [SAMPLE_BITS-1:0] LOWER_RESET = SAMPLE_BITS'(100);
    localparam logic [SAMPLE_BITS-1:0] UPPER_RESET = SAMPLE_BITS'(4000);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

    localparam cfg_idx_t CFG_LOWER_LIMIT = 2'd0;
    localparam cfg_idx_t CFG_UPPER_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_MUL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic insert;     // store the pair in both sorted chains
        logic release_pen;// emit an early-release result, clear count
        logic sum_start;  // clear accumulators and rank counter
        logic sum_step;   // add one kept rank per axis
        logic mul;        // reciprocal multiply of the sums
        logic finish;     // load the full result and strobe it
    } cmd_t;

    typedef struct packed {
        logic pen_down;
        logic in_range;
        logic last;       // this pair completes the set
        logic sum_last;   // final kept rank being added
    } status_t;

endpackage

FILE: hw/rtl/touch_sample_trimmed_mean.sv
// ---------------------------------------------------------------------------
// touch_sample_trimmed_mean
// Trimmed-mean filter for touch ADC sample pairs.
// ---------------------------------------------------------------------------
// Stored or rejected beats leave busy low; a pen release gives its result
// strobe in the cycle after it is accepted.
// The beat that completes the set holds busy through the summing, multiply
// and load states (one kept rank summed per cycle, one reciprocal multiply,
// one load), and done rises with the loaded result. The receiver cannot stall.
// Reset clears the count, the sequencer and the strobe; limits return to 100/4000.
`timescale 1ns / 1ps

module touch_sample_trimmed_mean (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tstm_pkg::sample_t  x_sample,
    input  tstm_pkg::sample_t  y_sample,
    input  logic               pen_down,
    output logic               done,
    output tstm_pkg::sample_t  x_filtered,
    output tstm_pkg::sample_t  y_filtered,
    output logic               complete,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  tstm_pkg::cfg_idx_t cfg_index,
    input  tstm_pkg::sample_t  cfg_data
);
    import tstm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tstm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tstm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .x_sample   (x_sample),
        .y_sample   (y_sample),
        .pen_down   (pen_down),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .x_filtered (x_filtered),
        .y_filtered (y_filtered),
        .complete   (complete),
        .done       (done)
    );

endmodule

FILE: hw/rtl/tstm_ctrl.sv
// ---------------------------------------------------------------------------
// tstm_ctrl
// Sequencer: accept, sum the kept ranks, divide, report.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tstm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tstm_pkg::status_t status,
    output tstm_pkg::cmd_t    cmd,
    output logic              busy
);
    import tstm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && status.pen_down && status.in_range && status.last)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (status.sum_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.release_pen = !status.pen_down;
                    cmd.insert      = status.pen_down && status.in_range;
                    cmd.sum_start   = status.pen_down && status.in_range && status.last;
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/tstm_datapath.sv
// ---------------------------------------------------------------------------
// tstm_datapath
// Limit registers, sorted insertion chains, rank accumulator and divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tstm_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  tstm_pkg::sample_t  x_sample,
    input  tstm_pkg::sample_t  y_sample,
    input  logic               pen_down,
    input  logic               cfg_valid,
    input  tstm_pkg::cfg_idx_t cfg_index,
    input  tstm_pkg::sample_t  cfg_data,
    input  tstm_pkg::cmd_t     cmd,
    output tstm_pkg::status_t  status,
    output tstm_pkg::sample_t  x_filtered,
    output tstm_pkg::sample_t  y_filtered,
    output logic               complete,
    output logic               done
);
    import tstm_pkg::*;

    typedef logic [SAMPLE_COUNT-1:0][SAMPLE_BITS-1:0] chain_t;

    // Insert v into a chain held largest first; only the first count entries are live.
    function automatic chain_t chain_insert(chain_t old, logic [CNT_W-1:0] count, sample_t v);
        chain_t                  res;
        logic [SAMPLE_COUNT-1:0] keep;
        for (int i = 0; i < SAMPLE_COUNT; i++)
        begin
            keep[i] = (CNT_W'(i) < count) && (old[i] >= v);
        end
        for (int i = 0; i < SAMPLE_COUNT; i++)
        begin
            if (keep[i])
            begin
                res[i] = old[i];
            end
            else if (i == 0)
            begin
                res[i] = v;
            end
            else if (keep[i-1])
            begin
                res[i] = v;
            end
            else
            begin
                res[i] = old[i-1];
            end
        end
        return res;
    endfunction

    sample_t               lower_reg;
    sample_t               upper_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    chain_t                x_chain_reg;
    chain_t                y_chain_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic [SUM_W-1:0]      x_acc_reg;
    logic [SUM_W-1:0]      y_acc_reg;
    logic [PROD_W-1:0]     x_prod_reg;
    logic [PROD_W-1:0]     y_prod_reg;
    sample_t               x_res_reg;
    sample_t               y_res_reg;
    logic                  complete_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      pick;
    int                    rank_pos;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= LOWER_RESET;
            upper_reg <= UPPER_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOWER_LIMIT: lower_reg <= cfg_data;
                CFG_UPPER_LIMIT: upper_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign status.pen_down = pen_down;
    assign status.in_range = (x_sample > lower_reg) && (x_sample < upper_reg) &&
                             (y_sample > lower_reg) && (y_sample < upper_reg);
    assign status.last     = (count_reg == CNT_W'(SAMPLE_COUNT - 1));
    assign status.sum_last = (rank_reg == RANK_W'(KEEP_COUNT - 1));

    always_comb
    begin
        count_next = count_reg;
        if (cmd.release_pen)
        begin
            count_next = '0;
        end
        else if (cmd.insert)
        begin
            count_next = status.last ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.release_pen || cmd.finish;
        end
    end

    // Kept rank, clamped to the smallest entry past the end of the set
    always_comb
    begin
        rank_pos = TRIM_LOW + int'(rank_reg);
        if (rank_pos > SAMPLE_COUNT - 1)
        begin
            pick = CNT_W'(SAMPLE_COUNT - 1);
        end
        else
        begin
            pick = CNT_W'(rank_pos);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            x_chain_reg <= chain_insert(x_chain_reg, count_reg, x_sample);
            y_chain_reg <= chain_insert(y_chain_reg, count_reg, y_sample);
        end
        if (cmd.sum_start)
        begin
            rank_reg  <= '0;
            x_acc_reg <= '0;
            y_acc_reg <= '0;
        end
        else if (cmd.sum_step)
        begin
            rank_reg  <= rank_reg + 1'b1;
            x_acc_reg <= x_acc_reg + SUM_W'(x_chain_reg[pick]);
            y_acc_reg <= y_acc_reg + SUM_W'(y_chain_reg[pick]);
        end
        if (cmd.mul)
        begin
            x_prod_reg <= PROD_W'(x_acc_reg) * PROD_W'(RECIP);
            y_prod_reg <= PROD_W'(y_acc_reg) * PROD_W'(RECIP);
        end
        if (cmd.release_pen)
        begin
            x_res_reg    <= '0;
            y_res_reg    <= '0;
            complete_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            x_res_reg    <= SAMPLE_BITS'(x_prod_reg >> DIV_SHIFT);
            y_res_reg    <= SAMPLE_BITS'(y_prod_reg >> DIV_SHIFT);
            complete_reg <= 1'b1;
        end
    end

    assign x_filtered = x_res_reg;
    assign y_filtered = y_res_reg;
    assign complete   = complete_reg;
    assign done       = done_reg;

endmodule

FILE: hw/rtl/tstm_checker.sv
// ---------------------------------------------------------------------------
// tstm_checker
// Port-level checks on the trimmed-mean filter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "touch_sample_trimmed_mean_assert.svh"

module tstm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              pen_down,
    input logic              done,
    input tstm_pkg::sample_t x_filtered,
    input tstm_pkg::sample_t y_filtered,
    input logic              complete
);
    import tstm_pkg::*;

    // Early release reports zeros
    `TSTM_ASSERT_NOW(a_release_zero, clk, rst_n, done && !complete, ~|{x_filtered, y_filtered})

    // Pen release beat answers on the next cycle
    `TSTM_ASSERT_NEXT(a_release_next, clk, rst_n, start && !busy && !pen_down, done && !complete)

    // No result while the filter is working on a set
    `TSTM_ASSERT_NOW(a_no_done_busy, clk, rst_n, busy, !done)

    // A full result ends a busy stretch
    `TSTM_ASSERT_NOW(a_full_after_busy, clk, rst_n, done && complete, $past(busy))

endmodule

bind touch_sample_trimmed_mean tstm_checker u_checker (.*);
